// ----- sv/sst_pkg.sv -----
`timescale 1ns / 1ps

package sst_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    localparam int REQ_W     = 2;
    localparam int HANDLE_W  = 16;
    localparam int USER_W    = 24;
    localparam int STATUS_W  = 2;
    localparam int IDX_OUT_W = 6;
    localparam int ENTRY_W   = HANDLE_W + USER_W;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } scan_state_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [HANDLE_W-1:0]  handle;
        logic [IDX_OUT_W-1:0] slot;
    } res_t;

    typedef struct packed {
        logic               re;
        logic [SLOT_W-1:0]  raddr;
        logic               we;
        logic [SLOT_W-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
    } mem_cmd_t;

endpackage

// ----- sv/sst_ram.sv -----
`timescale 1ns / 1ps

module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/sst_scan.sv -----
`timescale 1ns / 1ps

module sst_scan (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sst_pkg::REQ_W-1:0]       req_type,
    input  logic [sst_pkg::HANDLE_W-1:0]    conn_handle,
    input  logic [sst_pkg::USER_W-1:0]      user_key,
    output logic                            res_valid,
    input  logic                            res_take,
    output sst_pkg::res_t                   res,
    output sst_pkg::mem_cmd_t               mem_cmd,
    input  logic [sst_pkg::ENTRY_W-1:0]     mem_rdata
);

    import sst_pkg::*;

    scan_state_t          state_reg, state_next;
    logic [REQ_W-1:0]     req_reg, req_next;
    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    logic [USER_W-1:0]    user_reg, user_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic [SLOT_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                 hit_reg, hit_next;
    logic [SLOT_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [HANDLE_W-1:0]  hit_handle_reg, hit_handle_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;

    logic [HANDLE_W-1:0]  rd_handle;
    logic [USER_W-1:0]    rd_user;
    logic                 cmp_valid;
    logic                 match;

    assign rd_handle = mem_rdata[ENTRY_W-1 -: HANDLE_W];
    assign rd_user   = mem_rdata[USER_W-1:0];
    assign cmp_valid = valid_reg[cmp_idx_reg];

    always_comb
    begin
        unique case (req_reg)
            REQ_ADD:    match = !cmp_valid;
            REQ_REMOVE: match = cmp_valid && (rd_handle == handle_reg);
            REQ_LOOKUP: match = cmp_valid && (rd_user == user_reg);
            default:    match = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        handle_reg     <= handle_next;
        user_reg       <= user_next;
        cnt_reg        <= cnt_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_handle_reg <= hit_handle_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        handle_next     = handle_reg;
        user_next       = user_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_handle_next = hit_handle_reg;
        valid_next      = valid_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        mem_cmd.re      = 1'b0;
        mem_cmd.raddr   = cnt_reg[SLOT_W-1:0];
        mem_cmd.we      = 1'b0;
        mem_cmd.waddr   = hit_idx_reg;
        mem_cmd.wdata   = {handle_reg, user_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next    = req_type;
                    handle_next = conn_handle;
                    user_next   = user_key;
                    cnt_next    = '0;
                    pend_next   = 1'b0;
                    hit_next    = 1'b0;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                priority if (pend_reg && match)
                begin
                    hit_next        = 1'b1;
                    hit_idx_next    = cmp_idx_reg;
                    hit_handle_next = rd_handle;
                    pend_next       = 1'b0;
                    state_next      = ST_FIN;
                end
                else if (cnt_reg == CNT_W'(NUM_SLOTS))
                begin
                    hit_next   = 1'b0;
                    pend_next  = 1'b0;
                    state_next = ST_FIN;
                end
                else
                begin
                    mem_cmd.re   = 1'b1;
                    cmp_idx_next = cnt_reg[SLOT_W-1:0];
                    pend_next    = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
            end

            ST_FIN:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    if (hit_reg && (req_reg == REQ_ADD))
                    begin
                        mem_cmd.we              = 1'b1;
                        valid_next[hit_idx_reg] = 1'b1;
                    end
                    if (hit_reg && (req_reg == REQ_REMOVE))
                    begin
                        valid_next[hit_idx_reg] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status = hit_reg ? STAT_OK : ((req_reg == REQ_ADD) ? STAT_FULL : STAT_MISS);
        res.handle = (hit_reg && (req_reg == REQ_LOOKUP)) ? hit_handle_reg : '0;
        res.slot   = hit_reg ? IDX_OUT_W'(hit_idx_reg) : '0;
    end

endmodule

// ----- sv/session_slot_table_top.sv -----
`timescale 1ns / 1ps

// Session slot table.
// Input channel (in_valid/in_ready) carries one request beat: req_type,
// conn_handle, user_key. Output channel (out_valid/out_ready) carries one
// result beat per request: status, found_handle, slot_index.
// Add takes the lowest free slot, remove clears the lowest valid slot with
// a matching handle, lookup returns the handle of the lowest valid slot
// with a matching user id.
// Each request scans the slot memory one entry per cycle through its single
// read port, stopping at the first match. One request is in work at a time,
// so a new request is accepted only after the result of the last one has
// been loaded into the result register.
// in_ready is high only while no request is being scanned.
// Reset clears every valid mark at once; no clearing pass is needed.
// The result register holds its beat while out_ready is low; a finished
// scan then waits, and the table is updated only when its result moves
// into the result register.
module session_slot_table_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sst_pkg::REQ_W-1:0]       req_type,
    input  logic [sst_pkg::HANDLE_W-1:0]    conn_handle,
    input  logic [sst_pkg::USER_W-1:0]      user_key,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sst_pkg::STATUS_W-1:0]    status,
    output logic [sst_pkg::HANDLE_W-1:0]    found_handle,
    output logic [sst_pkg::IDX_OUT_W-1:0]   slot_index
);

    import sst_pkg::*;

    mem_cmd_t           mem_cmd;
    logic [ENTRY_W-1:0] mem_rdata;
    res_t               res;
    logic               res_valid;
    logic               res_take;
    logic               out_valid_reg, out_valid_next;
    res_t               out_res_reg, out_res_next;

    sst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_cmd.we),
        .waddr (mem_cmd.waddr),
        .wdata (mem_cmd.wdata),
        .re    (mem_cmd.re),
        .raddr (mem_cmd.raddr),
        .rdata (mem_rdata)
    );

    sst_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .conn_handle (conn_handle),
        .user_key    (user_key),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .mem_cmd     (mem_cmd),
        .mem_rdata   (mem_rdata)
    );

    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        priority if (res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_res_reg.status;
    assign found_handle = out_res_reg.handle;
    assign slot_index   = out_res_reg.slot;

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> out_valid)
        else $error("result beat not loaded");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request accepted during scan");

    a_write_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        mem_cmd.we |-> res_take && !mem_cmd.re)
        else $error("table written without result");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_OK) |-> (slot_index == '0) && (found_handle == '0))
        else $error("failed request carries nonzero fields");

endmodule

// ----- tb/session_slot_table_top_tb.sv -----
`timescale 1ns / 1ps

package session_tb_pkg;
    import sst_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    class slot_table_shadow;
        bit                  live [NUM_SLOTS];
        logic [HANDLE_W-1:0] handle_of [NUM_SLOTS];
        logic [USER_W-1:0]   user_of [NUM_SLOTS];
        res_t                awaited [$];
        int                  fail_count;
        int                  shown;

        function void flag(string msg);
            fail_count++;
            if (shown < 10)
            begin
                shown++;
                $display("%0t: %s", $realtime, msg);
            end
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [HANDLE_W-1:0] handle,
                                   logic [USER_W-1:0] user);
            res_t reply;
            int   hit;
            int   i;
            reply.status = STAT_MISS;
            reply.handle = '0;
            reply.slot   = '0;
            hit = -1;
            case (req)
                REQ_ADD:
                begin
                    for (i = 0; i < NUM_SLOTS && hit < 0; i++)
                        if (!live[i])
                            hit = i;
                    if (hit < 0)
                        reply.status = STAT_FULL;
                    else
                    begin
                        live[hit]      = 1'b1;
                        handle_of[hit] = handle;
                        user_of[hit]   = user;
                        reply.status   = STAT_OK;
                        reply.slot     = IDX_OUT_W'(hit);
                    end
                end
                REQ_REMOVE:
                begin
                    for (i = 0; i < NUM_SLOTS && hit < 0; i++)
                        if (live[i] && handle_of[i] == handle)
                            hit = i;
                    if (hit >= 0)
                    begin
                        live[hit]    = 1'b0;
                        reply.status = STAT_OK;
                        reply.slot   = IDX_OUT_W'(hit);
                    end
                end
                REQ_LOOKUP:
                begin
                    for (i = 0; i < NUM_SLOTS && hit < 0; i++)
                        if (live[i] && user_of[i] == user)
                            hit = i;
                    if (hit >= 0)
                    begin
                        reply.status = STAT_OK;
                        reply.handle = handle_of[hit];
                        reply.slot   = IDX_OUT_W'(hit);
                    end
                end
                default:
                begin
                end
            endcase
            awaited.push_back(reply);
        endfunction

        function void check_reply(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] handle,
                                  logic [IDX_OUT_W-1:0] slot);
            res_t want;
            if (awaited.size() == 0)
            begin
                flag($sformatf("unexpected beat: status %0d handle %h slot %0d",
                               status, handle, slot));
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status || handle !== want.handle || slot !== want.slot)
                flag($sformatf("mismatch (exp/got): status %0d/%0d, handle %h/%h, slot %0d/%0d",
                               want.status, status, want.handle, handle, want.slot, slot));
        endfunction
    endclass

endpackage

module session_slot_table_top_tb;
    import sst_pkg::*;
    import session_tb_pkg::*;

    localparam int IDLE_PCT        = 16;
    localparam int HOLD_OFF_AT     = 60;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_LIMIT     = 3000;
    localparam int TAIL_CYCLES     = 80;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [REQ_W-1:0]     req_type;
    logic [HANDLE_W-1:0]  conn_handle;
    logic [USER_W-1:0]    user_key;
    logic                 out_valid;
    logic                 out_ready;
    logic [STATUS_W-1:0]  status;
    logic [HANDLE_W-1:0]  found_handle;
    logic [IDX_OUT_W-1:0] slot_index;

    slot_table_shadow shadow;
    bit               steady = 1'b0;
    bit               held_off = 1'b0;
    int               beats_out = 0;
    int               quiet = 0;

    logic [HANDLE_W-1:0] handle_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                             16'h5A5A, 16'hA5A5, 16'h1234, 16'h00FF};
    logic [USER_W-1:0]   user_pool [8]   = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000,
                                             24'h5A5A5A, 24'hA5A5A5, 24'hABCDEF, 24'h00FF00};

    session_slot_table_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .conn_handle  (conn_handle),
        .user_key     (user_key),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .found_handle (found_handle),
        .slot_index   (slot_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_request(logic [REQ_W-1:0] req, logic [HANDLE_W-1:0] handle,
                                logic [USER_W-1:0] user);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        conn_handle <= handle;
        user_key    <= user;
        do
            @(posedge clk);
        while (!in_ready);
        shadow.note_request(req, handle, user);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (shadow.awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(0, 99) < 75)
            return handle_pool[$urandom_range(0, 7)];
        return HANDLE_W'($urandom);
    endfunction

    function automatic logic [USER_W-1:0] pick_user();
        if ($urandom_range(0, 99) < 70)
            return user_pool[$urandom_range(0, 7)];
        return USER_W'($urandom);
    endfunction

    function automatic logic [REQ_W-1:0] pick_req(int add_pct, int remove_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
            return REQ_ADD;
        if (roll < add_pct + remove_pct)
            return REQ_REMOVE;
        if (roll < 96)
            return REQ_LOOKUP;
        return REQ_UNUSED;
    endfunction

    task automatic run_phase(int items, int add_pct, int remove_pct, int steady_items);
        for (int n = 0; n < items; n++)
        begin
            steady = (n < steady_items);
            send_request(pick_req(add_pct, remove_pct), pick_handle(), pick_user());
        end
        steady = 1'b0;
    endtask

    initial
    begin
        shadow      = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = REQ_ADD;
        conn_handle = '0;
        user_key    = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_request(REQ_LOOKUP, 16'h0000, 24'h000000);
        send_request(REQ_REMOVE, 16'h0000, 24'h000000);
        send_request(REQ_UNUSED, 16'hFFFF, 24'hFFFFFF);
        send_request(REQ_ADD,    16'hFFFF, 24'hFFFFFF);
        send_request(REQ_ADD,    16'h0000, 24'h000000);
        send_request(REQ_ADD,    16'h1234, 24'hABCDEF);
        send_request(REQ_ADD,    16'h1234, 24'hABCDEF);
        send_request(REQ_LOOKUP, 16'h0000, 24'hFFFFFF);
        send_request(REQ_LOOKUP, 16'hFFFF, 24'h000000);
        send_request(REQ_LOOKUP, 16'h0000, 24'hABCDEF);
        send_request(REQ_REMOVE, 16'h1234, 24'h000000);
        send_request(REQ_LOOKUP, 16'h0000, 24'hABCDEF);
        send_request(REQ_ADD,    16'h5555, 24'h123456);
        send_request(REQ_REMOVE, 16'hFFFF, 24'hFFFFFF);
        send_request(REQ_LOOKUP, 16'h0000, 24'hFFFFFF);
        send_request(REQ_REMOVE, 16'h0000, 24'h000000);
        send_request(REQ_REMOVE, 16'h0000, 24'h000000);
        send_request(REQ_UNUSED, 16'h0000, 24'h000000);
        send_request(REQ_LOOKUP, 16'hFFFF, 24'h123456);
        send_request(REQ_REMOVE, 16'h1234, 24'hFFFFFF);
        send_request(REQ_REMOVE, 16'h5555, 24'h000000);

        // fill past capacity, then pause until the table has settled
        run_phase(130, 75, 10, 0);
        drain_results();
        run_phase(130, 15, 65, 0);
        run_phase(170, 40, 35, 70);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (shadow.fail_count == 0)
            $display("session_slot_table_top_tb: done, clean");
        else
            $display("session_slot_table_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held_off && beats_out >= HOLD_OFF_AT)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                beats_out++;
                shadow.check_reply(status, found_handle, slot_index);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("session_slot_table_top_tb: done, errors");
            $finish;
        end
    end

endmodule
